[rtl/rtt_pkg.sv]
// Package for the rectangle-to-trapezoid splitter: point and trapezoid types,
// the corner ordering and the trapezoid builder shared by the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps

package rtt_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] bottom;
        point_t             left_start;
        point_t             left_end;
        point_t             right_start;
        point_t             right_end;
    } trap_t;

    typedef struct packed {
        logic          valid;
        point_t [3:0]  q;
    } sorted_t;

    // true when a orders strictly after b: by y, then by x
    function automatic logic sorts_after(input point_t a, input point_t b);
        logic res;
        if ($signed(a.y) != $signed(b.y))
            res = $signed(a.y) > $signed(b.y);
        else
            res = $signed(a.x) > $signed(b.x);
        return res;
    endfunction

    function automatic point_t min_pt(input point_t a, input point_t b);
        return sorts_after(a, b) ? b : a;
    endfunction

    function automatic point_t max_pt(input point_t a, input point_t b);
        return sorts_after(a, b) ? a : b;
    endfunction

    function automatic trap_t make_trap(input logic signed [31:0] top,
                                        input logic signed [31:0] bottom,
                                        input point_t l0, input point_t l1,
                                        input point_t r0, input point_t r1);
        trap_t t;
        t.top         = top;
        t.bottom      = bottom;
        t.left_start  = l0;
        t.left_end    = l1;
        t.right_start = r0;
        t.right_end   = r1;
        return t;
    endfunction

endpackage

[rtl/rtt_ifs.sv]
// Valid/ready channel interfaces for the trapezoid splitter: corner items in,
// trapezoid items out. No dependencies.
`timescale 1ns / 1ps

interface rtt_corner_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;

    modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                    input ready);
    modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  output ready);
endinterface

interface rtt_trap_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] trap_top;
    logic signed [31:0] trap_bottom;
    logic signed [31:0] left_start_x;
    logic signed [31:0] left_start_y;
    logic signed [31:0] left_end_x;
    logic signed [31:0] left_end_y;
    logic signed [31:0] right_start_x;
    logic signed [31:0] right_start_y;
    logic signed [31:0] right_end_x;
    logic signed [31:0] right_end_y;
    logic               last_of_run;

    modport source (output valid, trap_top, trap_bottom, left_start_x, left_start_y,
                    left_end_x, left_end_y, right_start_x, right_start_y,
                    right_end_x, right_end_y, last_of_run,
                    input ready);
    modport sink (input valid, trap_top, trap_bottom, left_start_x, left_start_y,
                  left_end_x, left_end_y, right_start_x, right_start_y,
                  right_end_x, right_end_y, last_of_run,
                  output ready);
endinterface

[rtl/rtt_sort_stage.sv]
// Input register and four-corner sorting network of the trapezoid splitter.
// Depends on rtt_pkg and rtt_corner_if.
`timescale 1ns / 1ps

module rtt_sort_stage
    import rtt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rtt_corner_if.sink         corners,
    output sorted_t            sorted,
    input  logic               sorted_ready
);

    logic         valid_reg;
    logic         valid_next;
    point_t [3:0] pts_reg;
    point_t [3:0] pts_next;
    logic         take;

    point_t l0, l1, l2, l3;
    point_t m0, m1, m2, m3;

    assign corners.ready = !valid_reg || sorted_ready;
    assign take          = corners.valid && corners.ready;

    always_comb
    begin
        valid_next = valid_reg;
        pts_next   = pts_reg;
        if (take)
        begin
            valid_next     = 1'b1;
            pts_next[0].x  = corners.p0_x;
            pts_next[0].y  = corners.p0_y;
            pts_next[1].x  = corners.p1_x;
            pts_next[1].y  = corners.p1_y;
            pts_next[2].x  = corners.p2_x;
            pts_next[2].y  = corners.p2_y;
            pts_next[3].x  = corners.p3_x;
            pts_next[3].y  = corners.p3_y;
        end
        else if (sorted_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg <= pts_next;
    end

    always_comb
    begin
        l0 = min_pt(pts_reg[0], pts_reg[1]);
        l1 = max_pt(pts_reg[0], pts_reg[1]);
        l2 = min_pt(pts_reg[2], pts_reg[3]);
        l3 = max_pt(pts_reg[2], pts_reg[3]);
        m0 = min_pt(l0, l2);
        m2 = max_pt(l0, l2);
        m1 = min_pt(l1, l3);
        m3 = max_pt(l1, l3);
        sorted.valid = valid_reg;
        sorted.q[0]  = m0;
        sorted.q[1]  = min_pt(m1, m2);
        sorted.q[2]  = max_pt(m1, m2);
        sorted.q[3]  = m3;
    end

endmodule

[rtl/rtt_trap_split.sv]
// Trapezoid builder, band register and result register of the splitter:
// holds the non-empty bands of one item and sends them one per cycle while traps.ready is high.
// Depends on rtt_pkg and rtt_trap_if.
`timescale 1ns / 1ps

module rtt_trap_split
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sorted_t     sorted,
    output logic        sorted_ready,
    rtt_trap_if.source  traps
);

    trap_t [2:0] set_reg;
    trap_t [2:0] set_next;
    logic  [2:0] mask_reg;
    logic  [2:0] mask_next;
    trap_t       out_reg;
    trap_t       out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_last_reg;
    logic        out_last_next;

    trap_t [2:0] built;
    logic  [2:0] built_mask;
    logic  [2:0] pick;
    logic  [2:0] rest;
    trap_t       chosen;
    logic        out_free;
    logic        load;
    logic        flip;

    always_comb
    begin
        flip = $signed(sorted.q[1].x) > $signed(sorted.q[2].x);
        if (flip)
        begin
            built[0] = make_trap(sorted.q[0].y, sorted.q[1].y,
                                 sorted.q[0], sorted.q[2], sorted.q[0], sorted.q[1]);
            built[1] = make_trap(sorted.q[1].y, sorted.q[2].y,
                                 sorted.q[0], sorted.q[2], sorted.q[1], sorted.q[3]);
            built[2] = make_trap(sorted.q[2].y, sorted.q[3].y,
                                 sorted.q[2], sorted.q[3], sorted.q[1], sorted.q[3]);
        end
        else
        begin
            built[0] = make_trap(sorted.q[0].y, sorted.q[1].y,
                                 sorted.q[0], sorted.q[1], sorted.q[0], sorted.q[2]);
            built[1] = make_trap(sorted.q[1].y, sorted.q[2].y,
                                 sorted.q[1], sorted.q[3], sorted.q[0], sorted.q[2]);
            built[2] = make_trap(sorted.q[2].y, sorted.q[3].y,
                                 sorted.q[1], sorted.q[3], sorted.q[2], sorted.q[3]);
        end
        built_mask[0] = sorted.q[0].y != sorted.q[1].y;
        built_mask[1] = sorted.q[1].y != sorted.q[2].y;
        built_mask[2] = sorted.q[2].y != sorted.q[3].y;
    end

    always_comb
    begin
        out_free = !out_valid_reg || traps.ready;
        pick     = 3'b000;
        chosen   = set_reg[0];
        priority if (mask_reg[0])
        begin
            pick   = 3'b001;
            chosen = set_reg[0];
        end
        else if (mask_reg[1])
        begin
            pick   = 3'b010;
            chosen = set_reg[1];
        end
        else if (mask_reg[2])
        begin
            pick   = 3'b100;
            chosen = set_reg[2];
        end
        else
        begin
            pick   = 3'b000;
            chosen = set_reg[0];
        end
        rest = mask_reg & ~pick;

        sorted_ready = (mask_reg == 3'b000) || (out_free && (rest == 3'b000));
        load         = sorted.valid && sorted_ready;

        set_next       = load ? built : set_reg;
        mask_next      = load ? built_mask : (out_free ? rest : mask_reg);
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = mask_reg != 3'b000;
            out_next       = chosen;
            out_last_next  = rest == 3'b000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign traps.valid         = out_valid_reg;
    assign traps.trap_top      = out_reg.top;
    assign traps.trap_bottom   = out_reg.bottom;
    assign traps.left_start_x  = out_reg.left_start.x;
    assign traps.left_start_y  = out_reg.left_start.y;
    assign traps.left_end_x    = out_reg.left_end.x;
    assign traps.left_end_y    = out_reg.left_end.y;
    assign traps.right_start_x = out_reg.right_start.x;
    assign traps.right_start_y = out_reg.right_start.y;
    assign traps.right_end_x   = out_reg.right_end.x;
    assign traps.right_end_y   = out_reg.right_end.y;
    assign traps.last_of_run   = out_last_reg;

endmodule

[rtl/rectangle_to_trapezoids.sv]
// Top level of the rectangle-to-trapezoid splitter: sort stage feeding the
// trapezoid band stage. Depends on rtt_pkg, rtt_ifs, rtt_sort_stage, rtt_trap_split.
//
// Each corner item is sorted by y then x and split into up to three horizontal
// trapezoids; empty bands are dropped and the last trapezoid of an item carries
// last_of_run. The first trapezoid passes the input register, the band register
// and the result register. The single result port sends one trapezoid per cycle
// while the receiver is ready; the band stage takes the next item when the last band
// of the current one moves to the result register. Both channels are registered,
// and a new item is taken while results are still being sent.
`timescale 1ns / 1ps

module rectangle_to_trapezoids
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rtt_corner_if.sink  corners,
    rtt_trap_if.source  traps
);

    sorted_t sorted;
    logic    sorted_ready;

    rtt_sort_stage u_sort (
        .clk          (clk),
        .rst_n        (rst_n),
        .corners      (corners),
        .sorted       (sorted),
        .sorted_ready (sorted_ready)
    );

    rtt_trap_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .sorted       (sorted),
        .sorted_ready (sorted_ready),
        .traps        (traps)
    );

endmodule

[sim/rtt_trap_checker.sv]
// Checker for the rectangle-to-trapezoid splitter: watches both channels, predicts
// the trapezoids of each accepted corner item and compares every result field.
// Depends on rtt_pkg and rtt_ifs.
`timescale 1ns / 1ps

module rtt_trap_checker
    import rtt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rtt_corner_if corners,
    rtt_trap_if   traps,
    output int    errors,
    output int    outstanding
);

    typedef struct packed {
        trap_t shape;
        logic  last;
    } trap_item_t;

    trap_item_t expected_traps[$];

    // order by y then x as one unsigned key
    function automatic logic [63:0] sort_key(input point_t p);
        return {~p.y[31], p.y[30:0], ~p.x[31], p.x[30:0]};
    endfunction

    task automatic split_into_traps(input point_t [3:0] raw);
        point_t q [4];
        point_t t;
        trap_t  cand [3];
        trap_t  kept [3];
        int     j;
        int     n;
        for (int i = 0; i < 4; i++)
            q[i] = raw[i];
        for (int i = 1; i < 4; i++)
        begin
            t = q[i];
            j = i;
            while (j > 0 && sort_key(q[j - 1]) > sort_key(t))
            begin
                q[j] = q[j - 1];
                j--;
            end
            q[j] = t;
        end
        if ($signed(q[1].x) > $signed(q[2].x))
        begin
            cand[0] = '{q[0].y, q[1].y, q[0], q[2], q[0], q[1]};
            cand[1] = '{q[1].y, q[2].y, q[0], q[2], q[1], q[3]};
            cand[2] = '{q[2].y, q[3].y, q[2], q[3], q[1], q[3]};
        end
        else
        begin
            cand[0] = '{q[0].y, q[1].y, q[0], q[1], q[0], q[2]};
            cand[1] = '{q[1].y, q[2].y, q[1], q[3], q[0], q[2]};
            cand[2] = '{q[2].y, q[3].y, q[1], q[3], q[2], q[3]};
        end
        n = 0;
        for (int k = 0; k < 3; k++)
        begin
            if (cand[k].top != cand[k].bottom)
            begin
                kept[n] = cand[k];
                n++;
            end
        end
        for (int k = 0; k < n; k++)
            expected_traps.push_back('{shape: kept[k], last: (k == n - 1)});
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
        end
    endtask

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin : watch
        point_t [3:0] raw;
        trap_item_t   want;
        if (rst_n)
        begin
            if (traps.valid && traps.ready)
            begin
                if (expected_traps.size() == 0)
                begin
                    errors++;
                    $display("%0t: trapezoid expected none actual top %0d bottom %0d",
                             $time, traps.trap_top, traps.trap_bottom);
                end
                else
                begin
                    want = expected_traps.pop_front();
                    check_field("trap_top", want.shape.top, traps.trap_top);
                    check_field("trap_bottom", want.shape.bottom, traps.trap_bottom);
                    check_field("left_start_x", want.shape.left_start.x, traps.left_start_x);
                    check_field("left_start_y", want.shape.left_start.y, traps.left_start_y);
                    check_field("left_end_x", want.shape.left_end.x, traps.left_end_x);
                    check_field("left_end_y", want.shape.left_end.y, traps.left_end_y);
                    check_field("right_start_x", want.shape.right_start.x,
                                traps.right_start_x);
                    check_field("right_start_y", want.shape.right_start.y,
                                traps.right_start_y);
                    check_field("right_end_x", want.shape.right_end.x, traps.right_end_x);
                    check_field("right_end_y", want.shape.right_end.y, traps.right_end_y);
                    check_field("last_of_run", $signed({31'b0, want.last}),
                                $signed({31'b0, traps.last_of_run}));
                end
            end
            if (corners.valid && corners.ready)
            begin
                raw[0] = '{corners.p0_x, corners.p0_y};
                raw[1] = '{corners.p1_x, corners.p1_y};
                raw[2] = '{corners.p2_x, corners.p2_y};
                raw[3] = '{corners.p3_x, corners.p3_y};
                split_into_traps(raw);
            end
        end
        outstanding = expected_traps.size();
    end

endmodule

[sim/tb_rectangle_to_trapezoids.sv]
// Testbench top for rectangle_to_trapezoids: drives directed and random corner
// items with random idling on both sides and gives the verdict.
// Depends on rtt_pkg, rtt_ifs, rectangle_to_trapezoids and rtt_trap_checker.
`timescale 1ns / 1ps

module tb_rectangle_to_trapezoids;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   long_hold_req;
    int   errors;
    int   outstanding;

    rtt_corner_if corners_ch();
    rtt_trap_if   traps_ch();

    rectangle_to_trapezoids dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .corners (corners_ch),
        .traps   (traps_ch)
    );

    rtt_trap_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .corners     (corners_ch),
        .traps       (traps_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] coord(input int mode);
        unique case (mode)
            0, 1:    return $urandom;
            2:       return (int'($urandom_range(0, 8)) - 4) * ONE;
            default:
                unique case ($urandom_range(0, 4))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_corners(input logic signed [31:0] ax, ay, bx, by,
                                 input logic signed [31:0] cx, cy, dx, dy);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            corners_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        corners_ch.valid <= 1'b1;
        corners_ch.p0_x  <= ax;
        corners_ch.p0_y  <= ay;
        corners_ch.p1_x  <= bx;
        corners_ch.p1_y  <= by;
        corners_ch.p2_x  <= cx;
        corners_ch.p2_y  <= cy;
        corners_ch.p3_x  <= dx;
        corners_ch.p3_y  <= dy;
        do
            @(posedge clk);
        while (!corners_ch.ready);
        @(negedge clk);
    endtask

    initial
    begin : receiver
        int stall_left;
        traps_ch.ready = 1'b0;
        stall_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                traps_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                traps_ch.ready <= 1'b0;
                stall_left = 199;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                traps_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                traps_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_rectangle_to_trapezoids failed");
        $finish;
    end

    initial
    begin : stimulus
        int                 mode;
        int                 kind;
        int                 j;
        logic signed [31:0] xs [4];
        logic signed [31:0] ys [4];
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] tmp;
        rst_n            = 1'b0;
        quiet            = 1'b0;
        long_hold_req    = 1'b0;
        corners_ch.valid = 1'b0;
        corners_ch.p0_x  = '0;
        corners_ch.p0_y  = '0;
        corners_ch.p1_x  = '0;
        corners_ch.p1_y  = '0;
        corners_ch.p2_x  = '0;
        corners_ch.p2_y  = '0;
        corners_ch.p3_x  = '0;
        corners_ch.p3_y  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        offer_corners(0, 0, 10 * ONE, 0, 10 * ONE, 5 * ONE, 0, 5 * ONE);
        offer_corners(S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX);
        offer_corners(S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN);
        offer_corners(1, 7, 5, 7, -3, 7, S_MAX, 7);
        offer_corners(S_MIN, S_MAX, S_MAX, S_MAX, 0, S_MAX, -1, S_MAX);
        offer_corners(3, 3, 3, 3, 3, 3, 3, 3);
        offer_corners(-5, 5, 3, 9, 0, 0, 10, 2);
        offer_corners(0, -10, -10, 0, 10, 0, 0, 10);
        offer_corners(S_MAX, 0, S_MIN, 0, S_MAX, ONE, S_MIN, ONE);
        offer_corners(0, S_MIN, 1, S_MAX, -1, S_MIN, 2, S_MAX);
        offer_corners(4, 4, 4, 4, 8, 9, 0, 9);
        offer_corners(4, 4, 1, 10, 4, 4, 4, 4);
        offer_corners(0, 0, 10, 10, 5, 2, 0, 10);
        offer_corners(0, 0, 5, 1, -5, 2, 0, 3);
        offer_corners(-1, -1, 0, -1, -1, 0, 0, 0);
        offer_corners(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                      32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'shF0F0_F0F0, 32'sh0F0F_0F0F);
        offer_corners(0, 0, 3, 1, 3, 2, 0, 5);
        offer_corners(7, S_MAX, 7, S_MIN, 7, 0, 7, -1);
        offer_corners(S_MAX, -1, S_MIN, 1, 0, 0, 0, 0);
        offer_corners(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX);

        for (int n = 0; n < 350; n++)
        begin
            if (n == 120)
                long_hold_req = 1'b1;
            if (n == 290)
                quiet = 1'b1;
            mode = $urandom_range(0, 3);
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                a  = coord(mode);
                b  = coord(mode);
                c  = coord(mode);
                d  = coord(mode);
                xs = '{a, b, b, a};
                ys = '{c, c, d, d};
            end
            else if (kind < 8)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    xs[i] = coord(mode);
                    ys[i] = coord(mode);
                end
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    xs[i] = coord(2);
                    ys[i] = coord(2);
                end
                xs[1] = xs[0];
                ys[1] = ys[0];
            end
            for (int i = 3; i > 0; i--)
            begin
                j     = $urandom_range(0, i);
                tmp   = xs[i];
                xs[i] = xs[j];
                xs[j] = tmp;
                tmp   = ys[i];
                ys[i] = ys[j];
                ys[j] = tmp;
            end
            offer_corners(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
        end

        corners_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_rectangle_to_trapezoids passed");
        else
            $display("tb_rectangle_to_trapezoids failed");
        $finish;
    end

endmodule

[sim.f]
rtl/rtt_pkg.sv
rtl/rtt_ifs.sv
rtl/rtt_sort_stage.sv
rtl/rtt_trap_split.sv
rtl/rectangle_to_trapezoids.sv
sim/rtt_trap_checker.sv
sim/tb_rectangle_to_trapezoids.sv
